### sv/drdf_pkg.sv
// ----------------------------------------------------------------------------
// drdf_pkg: shared types and constants of the detection row decode filter
// Register indexes, field widths, packed result layout and box rounding helpers.
// ----------------------------------------------------------------------------
package drdf_pkg;

   localparam int VALUE_W = 32;
   localparam int CSR_W   = 17;
   localparam int CNT_W   = 11;
   localparam int CLS_W   = 10;
   localparam int ROW_W   = 16;
   localparam int PIX_W   = 15;
   localparam int RSP_W   = 120;

   typedef enum logic [1:0] {
      REG_CLASS_COUNT     = 2'd0,
      REG_ROW_LENGTH      = 2'd1,
      REG_SCORE_THRESHOLD = 2'd2
   } csr_index_type;

   localparam logic [CNT_W-1:0] CLASS_COUNT_RST     = 11'd80;
   localparam logic [CNT_W-1:0] ROW_LENGTH_RST      = 11'd84;
   localparam logic [CSR_W-1:0] SCORE_THRESHOLD_RST = 17'd16384;
   localparam logic [CNT_W-1:0] ROW_LENGTH_MIN      = 11'd5;
   localparam logic [CNT_W-1:0] BOX_VALUES          = 11'd4;
   localparam logic [CNT_W-1:0] CLASS_LIMIT         = 11'd1024;

   typedef struct packed {
      logic [PIX_W-1:0]   box_height;
      logic [PIX_W-1:0]   box_width;
      logic [PIX_W-1:0]   box_top;
      logic [PIX_W-1:0]   box_left;
      logic [ROW_W-1:0]   row_index;
      logic [30:0]        confidence;
      logic [CLS_W-1:0]   class_index;
   } result_type;

   // round(max(center - size/2 + 0.5, 0)), worked in units of 2^-17
   function automatic logic [PIX_W-1:0] edge_px(logic signed [VALUE_W-1:0] center,
                                                logic signed [VALUE_W-1:0] size);
      logic signed [35:0] u;
      logic [35:0]        r;
      u = 36'(center) + 36'(center) - 36'(size) + 36'sd65536;
      r = 36'(u) + 36'd65536;
      if (u < 0) begin
         return '0;
      end
      if (|r[35:32]) begin
         return '1;
      end
      return r[31:17];
   endfunction

   // round(size + 0.5), negative gives 0
   function automatic logic [PIX_W-1:0] size_px(logic signed [VALUE_W-1:0] size);
      logic signed [33:0] u;
      logic [33:0]        r;
      u = 34'(size) + 34'sd32768;
      r = 34'(u) + 34'd32768;
      if (u < 0) begin
         return '0;
      end
      if (|r[33:31]) begin
         return '1;
      end
      return r[30:16];
   endfunction

endpackage

### sv/detection_row_decode_filter.sv
// ----------------------------------------------------------------------------
// detection_row_decode_filter: detector row decode with class argmax and threshold
// Takes one Q16.16 tensor value per beat, tracks the best class score of each
// row and emits one box candidate at the end of a row whose score passes.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                     | tuser
//  req_     | in  | value[31:0]                               | frame_start
//  rsp_     | out | class, confidence, row, left, top, w, h   | -
//  csr_     | in  | write enable, index, 17-bit data          | -
//
//  one value per cycle; the row state updates in the accepting cycle and a
//  candidate enters a two-entry output buffer (output register plus skid)
//  req_tready is low only while both output entries are full
//  reset is synchronous and restores the registers and clears all row state
// ----------------------------------------------------------------------------
module detection_row_decode_filter
   import drdf_pkg::*;
#(
   parameter int MAX_CLASSES    = 1024,
   parameter int MAX_ROW_LENGTH = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [VALUE_W-1:0]   req_tdata,   // value[31:0]
   input  logic                 req_tuser,   // frame_start
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,   // class_index[9:0], confidence[40:10],
                                             // row_index[56:41], box_left[71:57],
                                             // box_top[86:72], box_width[101:87],
                                             // box_height[116:102], zero[119:117]
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int CLS_CAP_I = (MAX_CLASSES < 1024) ? MAX_CLASSES : 1024;
   localparam int ROW_CAP_I = (MAX_ROW_LENGTH < 2047) ? MAX_ROW_LENGTH : 2047;
   localparam logic [CNT_W-1:0] CLS_CAP = CNT_W'(CLS_CAP_I);
   localparam logic [CNT_W-1:0] ROW_CAP = CNT_W'(ROW_CAP_I);

   logic [CNT_W-1:0]          class_count_ff;
   logic [CNT_W-1:0]          row_length_ff;
   logic [CSR_W-1:0]          threshold_ff;

   logic [CNT_W-1:0]          pos_ff, pos_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic signed [VALUE_W-1:0] best_ff, best_in;
   logic [CLS_W-1:0]          best_cls_ff, best_cls_in;
   logic signed [VALUE_W-1:0] box_ff [4];

   logic                      head_valid_ff, skid_valid_ff;
   result_type                head_ff, skid_ff;
   result_type                result;

   logic [CNT_W-1:0]          rl_eff, cc_eff, cc_raw, p, cls_off;
   logic                      accept, row_end, emit, pop, in_class;
   logic signed [VALUE_W-1:0] v;

   assign v      = req_tdata;
   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;

   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = head_valid_ff;
   assign rsp_tdata  = {3'b000, head_ff};

   always_comb begin
      rl_eff = row_length_ff;
      if (rl_eff < ROW_LENGTH_MIN) begin
         rl_eff = ROW_LENGTH_MIN;
      end
      if (rl_eff > ROW_CAP) begin
         rl_eff = ROW_CAP;
      end
      cc_raw = (class_count_ff == '0) ? CNT_W'(1) : class_count_ff;
      cc_eff = cc_raw;
      if (cc_eff > CLS_CAP) begin
         cc_eff = CLS_CAP;
      end
      if (cc_eff > rl_eff - BOX_VALUES) begin
         cc_eff = rl_eff - BOX_VALUES;
      end
   end

   always_comb begin
      p        = req_tuser ? '0 : pos_ff;
      cls_off  = p - BOX_VALUES;
      in_class = (p >= BOX_VALUES) && (cls_off < cc_eff);
      best_in     = best_ff;
      best_cls_in = best_cls_ff;
      if (in_class && (p == BOX_VALUES || v > best_ff)) begin
         best_in     = v;
         best_cls_in = cls_off[CLS_W-1:0];
      end
      row_end = ({1'b0, p} + 12'd1) >= {1'b0, rl_eff};
      row_in  = req_tuser ? '0 : row_ff;
      pos_in  = row_end ? '0 : p + CNT_W'(1);
      emit    = row_end && (best_in > $signed({15'd0, threshold_ff}));
   end

   always_comb begin
      result.class_index = best_cls_in;
      result.confidence  = best_in[30:0];
      result.row_index   = row_in;
      result.box_left    = edge_px(box_ff[0], box_ff[2]);
      result.box_top     = edge_px(box_ff[1], box_ff[3]);
      result.box_width   = size_px(box_ff[2]);
      result.box_height  = size_px(box_ff[3]);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         class_count_ff <= CLASS_COUNT_RST;
         row_length_ff  <= ROW_LENGTH_RST;
         threshold_ff   <= SCORE_THRESHOLD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_CLASS_COUNT:     class_count_ff <= csr_wdata[CNT_W-1:0];
            REG_ROW_LENGTH:      row_length_ff  <= csr_wdata[CNT_W-1:0];
            REG_SCORE_THRESHOLD: threshold_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // row state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         row_ff      <= '0;
         best_ff     <= '0;
         best_cls_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            box_ff[i] <= '0;
         end
      end else if (accept) begin
         pos_ff      <= pos_in;
         row_ff      <= row_end ? row_in + ROW_W'(1) : row_in;
         best_ff     <= best_in;
         best_cls_ff <= best_cls_in;
         if (p < BOX_VALUES) begin
            box_ff[p[1:0]] <= v;
         end
      end
   end

   // output register and skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            if (skid_valid_ff) begin
               head_ff       <= skid_ff;
               skid_valid_ff <= 1'b0;
            end else if (accept && emit) begin
               head_ff <= result;
            end else begin
               head_valid_ff <= 1'b0;
            end
         end else if (accept && emit) begin
            if (!head_valid_ff) begin
               head_ff       <= result;
               head_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= result;
               skid_valid_ff <= 1'b1;
            end
         end
      end
   end

endmodule
